// ----- hdl/grid_local_maximum_marker_unit_defines.svh -----
// Assertion macros shared by the grid local maximum marker unit.
// Included by the top level; depends on nothing else.
`ifndef GRID_LOCAL_MAXIMUM_MARKER_UNIT_DEFINES_SVH
`define GRID_LOCAL_MAXIMUM_MARKER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLMM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glmm same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GLMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glmm next-cycle check failed");

`endif

// ----- hdl/glmm_pkg.sv -----
// Shared widths and types of the grid local maximum marker unit.
// Used by the channel interfaces and all modules but glmm_ram; depends on nothing.
package glmm_pkg;

   localparam int SIZE_W  = 11;
   localparam int DEPTH_W = 8;
   localparam int ROW_W   = 10;
   localparam int COL_W   = 10;

   // One classified cell handed from the front end to the back end.
   typedef struct packed {
      logic [ROW_W-1:0]   row;        // row of the incoming cell
      logic [COL_W-1:0]   column;
      logic [DEPTH_W-1:0] center;     // depth of the cell one row above
      logic [DEPTH_W-1:0] depth;      // depth of the incoming cell
      logic               cavity;     // verdict for the cell one row above
      logic               has_upper;  // the cell one row above is reported
      logic               last_row;   // the incoming cell is reported too
      logic               last_col;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ----- hdl/glmm_req_if.sv -----
// Input channel of the grid local maximum marker unit: one depth per transfer.
// Depends on glmm_pkg.
interface glmm_req_if;
   logic                          valid;
   logic                          ready;
   logic [glmm_pkg::DEPTH_W-1:0]  depth;

   modport source (output valid, output depth, input ready);
   modport sink (input valid, input depth, output ready);
endinterface

// ----- hdl/glmm_rsp_if.sv -----
// Result channel of the grid local maximum marker unit: one reported cell per transfer.
// Depends on glmm_pkg.
interface glmm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [glmm_pkg::ROW_W-1:0]    row;
   logic [glmm_pkg::COL_W-1:0]    column;
   logic [glmm_pkg::DEPTH_W-1:0]  cell_depth;
   logic                          is_cavity;
   logic                          frame_last;

   modport source (output valid, output row, output column, output cell_depth,
                   output is_cavity, output frame_last, input ready);
   modport sink (input valid, input row, input column, input cell_depth,
                 input is_cavity, input frame_last, output ready);
endinterface

// ----- hdl/grid_local_maximum_marker_unit.sv -----
// Grid local maximum marker: 4-neighbour strict maximum search on a square byte map.
// Throughput is one depth per cycle unless the full queue stalls the input: each depth takes
// one line store write and one prefetch read. Cells on the last row give two results, so
// there the result port limits the rate. Each result is held in the queue before it is offered.
// Synchronous reset clears counters and queue, sets map size 3; line stores need no clearing.
// Depends on glmm_pkg, both channel interfaces, glmm_front, glmm_queue, glmm_back and the defines.
`include "grid_local_maximum_marker_unit_defines.svh"

module grid_local_maximum_marker_unit #(
   parameter int MAX_SIZE    = 1024,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   glmm_req_if.sink                      req_ch,
   glmm_rsp_if.source                    rsp_ch,
   input  logic                          csr_write_enable,
   input  logic [glmm_pkg::SIZE_W-1:0]   csr_write_data
);

   // The front end reads the line stores two columns ahead, so the window of the
   // current column and the next one is always loaded when a depth arrives. It
   // judges the cell one row above the incoming depth, since that cell now has all
   // four neighbours known, and hands the verdict on to the queue.
   glmm_pkg::work_type      push_data;
   glmm_pkg::work_type      head;
   glmm_pkg::q_status_type  q_status;
   logic                    push_valid;
   logic                    pop;

   glmm_front #(
      .MAX_SIZE (MAX_SIZE)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .q_status         (q_status),
      .push_valid       (push_valid),
      .push_data        (push_data)
   );

   // The queue decouples the two sides: the front end keeps taking depths while a
   // finished result waits for the downstream side.
   glmm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   // The back end sends the upper-row cell first and, on the last row, the
   // incoming cell itself right after it, with the frame end marked on the
   // bottom-right cell.
   glmm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_ch)
   );

   // A cavity is never a border cell.
   `GLMM_ASSERT_IMPLY(a_cavity_interior, clock, reset, rsp_ch.valid && rsp_ch.is_cavity, (rsp_ch.row != '0) && (rsp_ch.column != '0))

   // The bottom-right cell is a border cell and never a cavity.
   `GLMM_ASSERT_IMPLY(a_last_not_cavity, clock, reset, rsp_ch.valid && rsp_ch.frame_last, !rsp_ch.is_cavity)

   // A classified cell pushed into an empty queue is offered in the next cycle.
   `GLMM_ASSERT_NEXT(a_push_shows, clock, reset, push_valid && q_status.empty, rsp_ch.valid)

endmodule

// ----- hdl/glmm_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; no package needed.
module glmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        write_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  logic [WIDTH-1:0]                            write_data,
   input  logic                                        read_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic [WIDTH-1:0]                            read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ----- hdl/glmm_front.sv -----
// Front end: accepts depths, keeps the two line stores and the window, and classifies cells.
// Depends on glmm_pkg, glmm_req_if and glmm_ram.
module glmm_front #(
   parameter int MAX_SIZE = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [glmm_pkg::SIZE_W-1:0]   csr_write_data,
   glmm_req_if.sink                      req,
   input  glmm_pkg::q_status_type        q_status,
   output logic                          push_valid,
   output glmm_pkg::work_type            push_data
);

   localparam int CW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int NW    = $clog2(MAX_SIZE + 1);
   localparam int SW    = glmm_pkg::SIZE_W;
   localparam int CmpW  = (NW > SW) ? NW : SW;
   localparam int DW    = glmm_pkg::DEPTH_W;
   localparam int LW    = 2 * DW;
   localparam int RW    = glmm_pkg::ROW_W;
   localparam int KW    = glmm_pkg::COL_W;

   logic [NW-1:0] side_ff, side_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [DW-1:0] prev_ff, prev_in;
   logic [LW-1:0] win_ff, win_in;        // {upper, middle} at the current column
   logic          fwd_ff, fwd_in;
   logic [LW-1:0] fwd_data_ff, fwd_data_in;

   logic [LW-1:0] ram_rdata;
   logic [LW-1:0] win_next;              // {upper, middle} at the next column
   logic          accept;
   logic [LW-1:0] wdata;
   logic [CW-1:0] raddr;
   logic [NW:0]   col_plus2;
   logic [NW-1:0] row_ext, col_ext;
   logic [DW-1:0] up, center, right, left;
   logic          last_row, last_col, interior, cavity;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   assign win_next = fwd_ff ? fwd_data_ff : ram_rdata;
   assign up       = win_ff[LW-1:DW];
   assign center   = win_ff[DW-1:0];
   assign right    = win_next[DW-1:0];
   assign left     = prev_ff;

   assign row_ext  = NW'(row_ff);
   assign col_ext  = NW'(col_ff);
   assign last_row = (row_ext + NW'(1)) >= side_ff;
   assign last_col = (col_ext + NW'(1)) >= side_ff;
   assign interior = (row_ext >= NW'(2)) && (col_ff != '0) && !last_col;
   assign cavity   = interior && (up < center) && (left < center) &&
                     (right < center) && (req.depth < center);

   // The cell at this column moves down one line: middle becomes upper.
   assign wdata = {center, req.depth};

   // Prefetch the entry two columns ahead, wrapping within the row.
   assign col_plus2 = (NW + 1)'(col_ff) + (NW + 1)'(2);
   always_comb begin
      if (side_ff == NW'(1)) begin
         raddr = '0;
      end else if (col_plus2 >= (NW + 1)'(side_ff)) begin
         raddr = CW'(col_plus2 - (NW + 1)'(side_ff));
      end else begin
         raddr = CW'(col_plus2);
      end
   end

   glmm_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_SIZE)
   ) u_line_ram (
      .clock        (clock),
      .write_enable (accept),
      .write_addr   (col_ff),
      .write_data   (wdata),
      .read_enable  (accept),
      .read_addr    (raddr),
      .read_data    (ram_rdata)
   );

   always_comb begin
      side_in     = side_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      prev_in     = prev_ff;
      win_in      = win_ff;
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            side_in = NW'(1);
         end else if (CmpW'(csr_write_data) > CmpW'(MAX_SIZE)) begin
            side_in = NW'(MAX_SIZE);
         end else begin
            side_in = NW'(csr_write_data);
         end
         row_in  = '0;
         col_in  = '0;
         prev_in = '0;
      end else if (accept) begin
         // A one-cell row reuses the entry it has just written.
         win_in      = (side_ff == NW'(1)) ? wdata : win_next;
         fwd_in      = (raddr == col_ff);
         fwd_data_in = wdata;
         if (last_col) begin
            col_in  = '0;
            prev_in = '0;
            row_in  = last_row ? '0 : row_ff + CW'(1);
         end else begin
            col_in  = col_ff + CW'(1);
            prev_in = center;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= NW'(3);
         row_ff  <= '0;
         col_ff  <= '0;
         prev_ff <= '0;
         fwd_ff  <= 1'b0;
      end else begin
         side_ff <= side_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         prev_ff <= prev_in;
         fwd_ff  <= fwd_in;
      end
      win_ff      <= win_in;
      fwd_data_ff <= fwd_data_in;
   end

   // Only cells that produce at least one result enter the queue.
   assign push_valid          = accept && ((row_ff != '0) || last_row);
   assign push_data.row       = RW'(row_ff);
   assign push_data.column    = KW'(col_ff);
   assign push_data.center    = center;
   assign push_data.depth     = req.depth;
   assign push_data.cavity    = cavity;
   assign push_data.has_upper = (row_ff != '0);
   assign push_data.last_row  = last_row;
   assign push_data.last_col  = last_col;

endmodule

// ----- hdl/glmm_queue.sv -----
// Short register queue of classified cells between front end and back end.
// Depends on glmm_pkg.
module glmm_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  glmm_pkg::work_type      push_data,
   input  logic                    pop,
   output glmm_pkg::work_type      head,
   output glmm_pkg::q_status_type  status
);

   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   glmm_pkg::work_type entries_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNTW'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ----- hdl/glmm_back.sv -----
// Back end: expands each queued cell into one or two result transfers.
// Depends on glmm_pkg and glmm_rsp_if.
module glmm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  glmm_pkg::work_type      head,
   input  glmm_pkg::q_status_type  q_status,
   output logic                    pop,
   glmm_rsp_if.source              rsp
);

   localparam int RW = glmm_pkg::ROW_W;

   // Set once the upper-row result of a last-row head entry has gone out.
   logic phase_ff, phase_in;
   logic first;
   logic transfer;

   assign first    = head.has_upper && !phase_ff;
   assign rsp.valid = !q_status.empty;
   assign transfer = rsp.valid && rsp.ready;

   always_comb begin
      if (first) begin
         rsp.row        = head.row - RW'(1);
         rsp.cell_depth = head.center;
         rsp.is_cavity  = head.cavity;
         rsp.frame_last = 1'b0;
      end else begin
         rsp.row        = head.row;
         rsp.cell_depth = head.depth;
         rsp.is_cavity  = 1'b0;
         rsp.frame_last = head.last_col;
      end
   end
   assign rsp.column = head.column;

   always_comb begin
      phase_in = phase_ff;
      pop      = 1'b0;
      if (transfer) begin
         if (first && head.last_row) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            pop      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- tb/tb_grid_local_maximum_marker_unit.sv -----
// Self-checking testbench for grid_local_maximum_marker_unit: streams depth maps in raster
// order and checks every reported cell against a built-in prediction of the marker.
// Depends on glmm_pkg, glmm_req_if, glmm_rsp_if and the unit itself.
module tb_grid_local_maximum_marker_unit;

   localparam int ROW_W   = glmm_pkg::ROW_W;
   localparam int COL_W   = glmm_pkg::COL_W;
   localparam int DEPTH_W = glmm_pkg::DEPTH_W;
   localparam int SIZE_W  = glmm_pkg::SIZE_W;

   // Largest side the block handles; larger register values are clamped to it.
   localparam int MAX_SIDE       = 1024;
   // Cycles to let pass before a size write, so the block is surely quiet.
   localparam int SETTLE_CYCLES  = 16;
   // The long receiver hold-off; long enough for the block to fill and stall its input.
   localparam int LONG_HOLD      = 150;
   // Cycles without any transfer after which the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;

   // One reported cell, laid out as the result channel carries it.
   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   column;
      logic [DEPTH_W-1:0] cell_depth;
      logic               is_cavity;
      logic               frame_last;
   } cell_report_type;

   // How random depths are drawn. Full range covers every bit, tie-heavy values make
   // many equal neighbours, and peaks alternate high and low cells so that odd-sided
   // maps form a checkerboard full of cavities.
   typedef enum logic [1:0] {
      DEPTH_FULL_RANGE,
      DEPTH_TIE_HEAVY,
      DEPTH_PEAKS,
      DEPTH_MIXED
   } depth_style_type;

   logic clock;
   logic reset;
   logic               csr_write_enable;
   logic [SIZE_W-1:0]  csr_write_data;

   glmm_req_if req_ch ();
   glmm_rsp_if rsp_ch ();

   grid_local_maximum_marker_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // ---------------------------------------------------------------------------------
   // Predictor state: our own copy of the map size, the two line stores, the position
   // of the next incoming cell and the row-above depth one column to the left.
   // ---------------------------------------------------------------------------------
   logic [SIZE_W-1:0]  map_size;
   logic [DEPTH_W-1:0] upper_row [MAX_SIDE];
   logic [DEPTH_W-1:0] middle_row [MAX_SIDE];
   int                 row_pos;
   int                 col_pos;
   logic [DEPTH_W-1:0] left_depth;

   // Depths waiting to be offered, and cells that the block still owes us.
   logic [DEPTH_W-1:0] depth_backlog [$];
   cell_report_type    owed_cells [$];

   // Stimulus shaping, set by the sequence and read by the driver and receiver.
   bit bursty_sender;
   int rsp_stall_mode;
   int hold_request;

   // Bookkeeping for the checks and the closing summary.
   int  mismatch_count;
   int  depths_sent;
   int  cells_checked;
   int  cavities_seen;
   int  frames_seen;
   int  size_writes;
   bit  req_taken;

   // Sample data used in the directed part. The first is a 3x3 map whose center is
   // a clear cavity; in the second the center ties its upper and left neighbours, so a
   // strict comparison must leave it unflagged.
   logic [DEPTH_W-1:0] peak_grid [9] = '{8'd0, 8'd10, 8'd0, 8'd10, 8'd255, 8'd10,
                                         8'd0, 8'd10, 8'd0};
   logic [DEPTH_W-1:0] tie_grid [9]  = '{8'd1, 8'd200, 8'd1, 8'd200, 8'd200, 8'd199,
                                         8'd1, 8'd199, 8'd1};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A write of the size register restarts the frame; line contents are kept.
   function automatic void restart_frame(logic [SIZE_W-1:0] size);
      map_size   = size;
      row_pos    = 0;
      col_pos    = 0;
      left_depth = '0;
   endfunction

   // Works out which cells one incoming depth completes. The cell one row above is
   // reported once its lower neighbour arrives; on the last row the incoming cell is
   // reported right after it, since it has no lower neighbour to wait for.
   function automatic void judge_depth(logic [DEPTH_W-1:0] depth);
      int                 side;
      logic [DEPTH_W-1:0] up;
      logic [DEPTH_W-1:0] center;
      logic [DEPTH_W-1:0] right;
      logic               interior;
      logic               last_row;
      logic               last_col;
      cell_report_type    report;

      // A size of zero behaves as one, and sizes past the store depth are clamped.
      if (map_size == 0) begin
         side = 1;
      end else if (map_size > MAX_SIDE) begin
         side = MAX_SIDE;
      end else begin
         side = map_size;
      end

      up       = upper_row[col_pos];
      center   = middle_row[col_pos];
      right    = (col_pos + 1 < side) ? middle_row[col_pos + 1] : '0;
      last_row = (row_pos + 1 >= side);
      last_col = (col_pos + 1 >= side);

      if (row_pos >= 1) begin
         // Only cells with all four neighbours inside the map can be cavities.
         interior          = (row_pos >= 2) && (col_pos >= 1) && (col_pos + 1 < side);
         report.row        = ROW_W'(row_pos - 1);
         report.column     = COL_W'(col_pos);
         report.cell_depth = center;
         report.is_cavity  = interior && (up < center) && (left_depth < center) &&
                             (right < center) && (depth < center);
         report.frame_last = 1'b0;
         owed_cells.push_back(report);
      end
      if (last_row) begin
         report.row        = ROW_W'(row_pos);
         report.column     = COL_W'(col_pos);
         report.cell_depth = depth;
         report.is_cavity  = 1'b0;
         report.frame_last = last_col;
         owed_cells.push_back(report);
      end

      upper_row[col_pos]  = center;
      middle_row[col_pos] = depth;
      left_depth          = center;

      if (last_col) begin
         col_pos    = 0;
         left_depth = '0;
         row_pos    = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   function automatic logic [DEPTH_W-1:0] pick_depth(depth_style_type style, int idx);
      depth_style_type mode;

      mode = style;
      if (style == DEPTH_MIXED) begin
         mode = depth_style_type'($urandom_range(0, 2));
      end
      case (mode)
         DEPTH_TIE_HEAVY: begin
            return DEPTH_W'($urandom_range(0, 2));
         end
         DEPTH_PEAKS: begin
            return (idx % 2) ? DEPTH_W'($urandom_range(192, 255))
                             : DEPTH_W'($urandom_range(0, 63));
         end
         default: begin
            return DEPTH_W'($urandom_range(0, 255));
         end
      endcase
   endfunction

   task automatic queue_random_depths(int count, depth_style_type style);
      for (int i = 0; i < count; i++) begin
         depth_backlog.push_back(pick_depth(style, i));
      end
   endtask

   // Waits until every queued depth has been taken and every owed cell has come back.
   task automatic drain;
      while (depth_backlog.size() != 0 || owed_cells.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Writes the size register once the block is quiet. Depths on the first row give
   // no result, so a fixed settle time follows the drain before the write.
   task automatic write_map_size(logic [SIZE_W-1:0] size);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= size;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------
   // Driver: offers queued depths in bursts of random length, separated by random gaps when bursty.
   // An offer is never withdrawn; the next one is chosen only after a transfer.
   // ---------------------------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.depth <= '0;
         burst_left   = 0;
         gap_left     = 0;
      end else if (!req_ch.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (depth_backlog.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.depth <= depth_backlog[0];
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = bursty_sender ? $urandom_range(1, 7) : 0;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Receiver: its ready follows one of three stall patterns, and on request it holds
   // off for a long stretch, counted here, while the driver keeps offering depths.
   // ---------------------------------------------------------------------------------
   int          hold_left;
   logic [15:0] stall_pattern;
   int          pattern_bit;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready  <= 1'b0;
         hold_left     = 0;
         stall_pattern = 16'hFFFF;
         pattern_bit   = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (hold_request > 0) begin
         hold_left    = hold_request - 1;
         hold_request = 0;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (rsp_stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: begin
               // A repeating 16-bit pattern, redrawn at each wrap, with a few ready slots forced.
               rsp_ch.ready <= stall_pattern[pattern_bit];
               if (pattern_bit == 15) begin
                  pattern_bit   = 0;
                  stall_pattern = 16'($urandom()) | 16'h8421;
               end else begin
                  pattern_bit++;
               end
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Monitor: at each rising edge it records size writes and depth transfers in the
   // predictor, and checks each result transfer against the oldest owed cell.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      cell_report_type seen;
      cell_report_type want;

      if (reset) begin
         req_taken = 1'b0;
         owed_cells.delete();
         map_size   = SIZE_W'(3);
         row_pos    = 0;
         col_pos    = 0;
         left_depth = '0;
      end else begin
         req_taken = req_ch.valid && req_ch.ready;
         if (csr_write_enable) begin
            restart_frame(csr_write_data);
            size_writes++;
         end
         if (req_taken) begin
            judge_depth(req_ch.depth);
            void'(depth_backlog.pop_front());
            depths_sent++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.row        = rsp_ch.row;
            seen.column     = rsp_ch.column;
            seen.cell_depth = rsp_ch.cell_depth;
            seen.is_cavity  = rsp_ch.is_cavity;
            seen.frame_last = rsp_ch.frame_last;
            if (owed_cells.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("unexpected cell: row %0d col %0d depth %0d cavity %b last %b",
                           seen.row, seen.column, seen.cell_depth, seen.is_cavity,
                           seen.frame_last);
               end
            end else begin
               want = owed_cells.pop_front();
               cells_checked++;
               if (seen.is_cavity === 1'b1) cavities_seen++;
               if (seen.frame_last === 1'b1) frames_seen++;
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("cell mismatch: want row %0d col %0d depth %0d cav %b last %b",
                              want.row, want.column, want.cell_depth, want.is_cavity,
                              want.frame_last);
                     $display("               got  row %0d col %0d depth %0d cav %b last %b",
                              seen.row, seen.column, seen.cell_depth, seen.is_cavity,
                              seen.frame_last);
                  end
               end
            end
         end
      end
   end

   // Watchdog: counts cycles in which no transfer of any kind happens.
   int idle_cycles;

   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d cells still owed",
                     idle_cycles, owed_cells.size());
            $display("** grid_local_maximum_marker_unit: FAILED **");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_ch.valid     = 1'b0;
      req_ch.depth     = '0;
      rsp_ch.ready     = 1'b0;
      bursty_sender    = 1'b1;
      rsp_stall_mode   = 1;
      hold_request     = 0;
      mismatch_count   = 0;
      depths_sent      = 0;
      cells_checked    = 0;
      cavities_seen    = 0;
      frames_seen      = 0;
      size_writes      = 0;
      for (int i = 0; i < MAX_SIDE; i++) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset size of three: a clear cavity, then a tie that a
      // strict comparison must reject.
      foreach (peak_grid[i]) depth_backlog.push_back(peak_grid[i]);
      foreach (tie_grid[i]) depth_backlog.push_back(tie_grid[i]);

      // One-cell maps: every depth comes straight back as a bordered last cell. A size
      // of zero must behave the same way.
      write_map_size(SIZE_W'(1));
      depth_backlog.push_back(8'd255);
      depth_backlog.push_back(8'd0);
      write_map_size(SIZE_W'(0));
      depth_backlog.push_back(8'd128);

      // A two-sided map has no interior, so even a high cell stays unflagged.
      write_map_size(SIZE_W'(2));
      depth_backlog.push_back(8'd255);
      depth_backlog.push_back(8'd0);
      depth_backlog.push_back(8'd0);
      depth_backlog.push_back(8'd255);

      // Random part. One full 5x5 frame with bursty input and random stalls.
      write_map_size(SIZE_W'(5));
      queue_random_depths(25, DEPTH_MIXED);

      // 7x7 maps: a long receiver hold-off while the sender keeps offering, so the
      // block fills and stalls its input. The next frame then starts after a full pause.
      write_map_size(SIZE_W'(7));
      rsp_stall_mode = 2;
      hold_request   = LONG_HOLD;
      queue_random_depths(49, DEPTH_PEAKS);
      drain();
      queue_random_depths(7, DEPTH_TIE_HEAVY);
      drain();

      // A stretch with no idling on either side.
      bursty_sender  = 1'b0;
      rsp_stall_mode = 0;
      queue_random_depths(7, DEPTH_MIXED);

      // A size beyond the store depth is clamped to 1024; the first cells of such a
      // row give no result yet.
      write_map_size(SIZE_W'(2047));
      rsp_stall_mode = 1;
      queue_random_depths(4, DEPTH_TIE_HEAVY);

      // The largest legal size, cut short mid-row by the next write, which must
      // restart the frame.
      write_map_size(SIZE_W'(MAX_SIDE));
      queue_random_depths(3, DEPTH_FULL_RANGE);
      write_map_size(SIZE_W'(3));
      bursty_sender = 1'b1;
      rsp_stall_mode = 2;
      queue_random_depths(9, DEPTH_PEAKS);

      write_map_size(SIZE_W'(1));
      queue_random_depths(4, DEPTH_FULL_RANGE);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d depths sent over %0d size writes; %0d cells checked, %0d cavities, %0d frames",
               depths_sent, size_writes, cells_checked, cavities_seen, frames_seen);
      $display("%0d mismatches, %0d cells still owed", mismatch_count, owed_cells.size());
      if (mismatch_count == 0 && owed_cells.size() == 0) begin
         $display("** grid_local_maximum_marker_unit: PASSED **");
      end else begin
         $display("** grid_local_maximum_marker_unit: FAILED **");
      end
      $finish;
   end

endmodule
